/* rtl/msdg_pkg.sv */
// ----------------------------------------------------------------------------
// msdg_pkg
// Shared types and constants of the multichannel step/direction generator.
// ----------------------------------------------------------------------------
package msdg_pkg;

	localparam int ChannelsDef = 8;
	localparam int PosW        = 16;
	localparam int ChanFieldW  = 3;
	localparam int LevelW      = 8;
	localparam int InDataW     = 24;
	localparam int OutDataW    = 24;
	localparam int CfgAddrW    = 1;

	// register indexes of the configuration port
	localparam logic [CfgAddrW-1:0] RegPosMax = 1'd0;
	localparam logic [CfgAddrW-1:0] RegPosMin = 1'd1;

	localparam logic [PosW-1:0] PosMaxRst = 16'd100;
	localparam logic [PosW-1:0] PosMinRst = 16'd0;

	// request kinds carried on tuser
	localparam logic ReqTick = 1'b0;
	localparam logic ReqSet  = 1'b1;

	// per-channel state word kept in the channel memory
	typedef struct packed {
		logic [PosW-1:0] per;
		logic [PosW-1:0] cnt;
		logic [PosW-1:0] pos;
	} chan_word_t;

	// result of one pass of the channel unit
	typedef struct packed {
		chan_word_t word;
		logic       wr;
		logic       adv;
		logic       flip;
	} chan_upd_t;

endpackage

/* rtl/multichannel_step_dir_generator.sv */
// ----------------------------------------------------------------------------
// multichannel_step_dir_generator
// Step/direction generator for CHANNELS stepper channels with reversal limits.
// ----------------------------------------------------------------------------
// A tick transaction walks the channels one per cycle through a single channel
// unit fed from a one-read-port channel memory; its result is loaded into the
// output register in S_DONE after S_TICK and S_DRAIN, and the block takes the
// next item once it is back in S_IDLE. A set-period transaction does a
// read-modify-write of one memory word in S_SET and S_SET_WR (a channel
// beyond CHANNELS goes straight to S_DONE). The input side is not ready while
// an item is being worked on; a finished result waits in the output register
// while the next item is taken.
// Channels above 7 run but do not show in the 8-bit result fields.
module multichannel_step_dir_generator #(
	parameter int CHANNELS = msdg_pkg::ChannelsDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [msdg_pkg::CfgAddrW-1:0]   cfg_addr,
	input  logic [msdg_pkg::PosW-1:0]       cfg_wdata,
	// requests
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [msdg_pkg::InDataW-1:0]    s_tdata,  // channel[2:0], period[18:3], zero pad
	input  logic                            s_tuser,  // req_type
	// results
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [msdg_pkg::OutDataW-1:0]   m_tdata   // step_levels, dir_levels, reversed_mask
);
	import msdg_pkg::*;

	localparam int ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [ChW-1:0] LastCh = ChW'(CHANNELS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SET,
		S_SET_WR,
		S_TICK,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [PosW-1:0]      pos_max_q;
	logic [PosW-1:0]      pos_min_q;
	logic [ChW-1:0]       chan_q;
	logic [PosW-1:0]      per_q;
	logic [ChW-1:0]       ch_q;
	logic [ChW-1:0]       ch_s1;
	logic                 proc_s1;
	logic [CHANNELS-1:0]  dir_q;
	logic [CHANNELS-1:0]  step_q;
	logic [CHANNELS-1:0]  flip_q;
	logic [CHANNELS-1:0]  vld_q;
	logic                 m_tvalid_q;
	logic [OutDataW-1:0]  m_tdata_q;

	chan_word_t           mem_q [CHANNELS];
	chan_word_t           rd_data_s1;
	logic                 rd_vld_s1;

	logic                 s_acc;
	logic [ChanFieldW-1:0] s_chan;
	logic [PosW-1:0]      s_per;
	logic                 out_free;
	logic [ChW-1:0]       rd_addr;
	chan_word_t           cur;
	chan_upd_t            upd;
	logic                 wr_en;
	logic [ChW-1:0]       wr_addr;
	chan_word_t           wr_data;

	assign s_chan   = s_tdata[ChanFieldW-1:0];
	assign s_per    = s_tdata[ChanFieldW +: PosW];
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign rd_addr  = (state_q == S_SET) ? chan_q : ch_q;
	// never-written entries read as the reset value
	assign cur      = rd_vld_s1 ? rd_data_s1 : '0;

	msdg_chan_unit u_unit (
		.word    (cur),
		.dir     (dir_q[ch_s1]),
		.pos_max (pos_max_q),
		.pos_min (pos_min_q),
		.upd     (upd)
	);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ch_s1;
		wr_data = upd.word;
		if (state_q == S_SET_WR) begin
			wr_en       = 1'b1;
			wr_addr     = chan_q;
			wr_data     = cur;
			wr_data.per = per_q;
		end else if (proc_s1 && upd.wr) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pos_max_q  <= PosMaxRst;
			pos_min_q  <= PosMinRst;
			chan_q     <= '0;
			per_q      <= '0;
			ch_q       <= '0;
			ch_s1      <= '0;
			proc_s1    <= 1'b0;
			dir_q      <= '0;
			step_q     <= '0;
			flip_q     <= '0;
			vld_q      <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					RegPosMax: pos_max_q <= cfg_wdata;
					RegPosMin: pos_min_q <= cfg_wdata;
					default: ;
				endcase
			end

			rd_vld_s1 <= vld_q[rd_addr];
			proc_s1   <= (state_q == S_TICK);
			ch_s1     <= ch_q;

			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end

			if (proc_s1 && upd.adv) begin
				step_q[ch_s1] <= ~step_q[ch_s1];
				if (upd.flip) begin
					dir_q[ch_s1]  <= ~dir_q[ch_s1];
					flip_q[ch_s1] <= 1'b1;
				end
			end

			// the done state reloads the output register itself
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						chan_q <= ChW'(s_chan);
						per_q  <= s_per;
						ch_q   <= '0;
						flip_q <= '0;
						if (s_tuser == ReqSet) begin
							// channels beyond the configured count are ignored
							state_q <= (32'(s_chan) < CHANNELS) ? S_SET : S_DONE;
						end else begin
							state_q <= S_TICK;
						end
					end
				end
				S_SET: begin
					state_q <= S_SET_WR;
				end
				S_SET_WR: begin
					state_q <= S_DONE;
				end
				S_TICK: begin
					if (ch_q == LastCh) begin
						state_q <= S_DRAIN;
					end else begin
						ch_q <= ch_q + ChW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {LevelW'(flip_q), LevelW'(dir_q), LevelW'(step_q)};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/msdg_chan_unit.sv */
// ----------------------------------------------------------------------------
// msdg_chan_unit
// Advances one channel by one tick: counter compare, head move, limit check.
// ----------------------------------------------------------------------------
module msdg_chan_unit (
	input  msdg_pkg::chan_word_t      word,
	input  logic                      dir,
	input  logic [msdg_pkg::PosW-1:0] pos_max,
	input  logic [msdg_pkg::PosW-1:0] pos_min,
	output msdg_pkg::chan_upd_t       upd
);
	import msdg_pkg::*;

	logic            active;
	logic            adv;
	logic [PosW-1:0] pos_n;
	logic [PosW-1:0] cnt_n;

	assign active = (word.per != '0);
	assign adv    = active && (word.cnt >= word.per);
	// moving down adds all ones, wrapping at 16 bits
	assign pos_n  = word.pos + (dir ? {PosW{1'b1}} : PosW'(1));
	assign cnt_n  = word.cnt + PosW'(1);

	always_comb begin
		upd.word.per = word.per;
		upd.word.cnt = adv ? '0 : cnt_n;
		upd.word.pos = adv ? pos_n : word.pos;
		upd.wr       = active;
		upd.adv      = adv;
		upd.flip     = adv && ((pos_n == pos_max) || (pos_n == pos_min));
	end

endmodule

/* rtl/msdg_checker.sv */
// ----------------------------------------------------------------------------
// msdg_checker
// Port-level checks of the step/direction generator, bound to the top level.
// ----------------------------------------------------------------------------
module msdg_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [msdg_pkg::OutDataW-1:0]   m_tdata
);
	import msdg_pkg::*;

	logic s_acc;
	logic m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	// one item at a time: busy right after a transaction is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_tready)
		else $error("input ready right after an accepted transaction");

	// a result never shows up in the cycle right after its request
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !$rose(m_tvalid))
		else $error("result appeared one cycle after request");

	// a result is not produced while the input side is idle-ready and no work pending
	a_result_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result raised without an item in work");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed or dropped");

	// after a result is taken, no new one appears without a new request being worked
	a_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		(m_acc && s_tready && !s_tvalid) |=> !m_tvalid)
		else $error("result repeated without a request");

endmodule

bind multichannel_step_dir_generator msdg_checker u_msdg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
